// ===== rtl/pcma_pkg.sv =====
// ----------------------------------------------------------------------------
// pcma_pkg: shared types and constants for the phase current moving average
// Widths, register codes, reset values and the ring control bundle.
// ----------------------------------------------------------------------------
package pcma_pkg;

    localparam int MAX_WINDOW = 8;
    localparam int SAMPLE_W   = 12;
    localparam int DIFF_SUM_W = SAMPLE_W + 2;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WLOG2_W    = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'd4095;
    localparam logic [SAMPLE_W-1:0] BIAS_RESET  = 12'd0;
    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 12'd2000;
    localparam logic [WLOG2_W-1:0]  WLOG2_RESET = 2'd2;
    localparam logic [WLOG2_W-1:0]  WLOG2_WIDE  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_BIAS      = 2'd0,
        CFG_WINDOW_LOG2   = 2'd1,
        CFG_CURRENT_LIMIT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                clear;
        logic                wide;
        logic [SAMPLE_W-1:0] current_limit;
    } t_ring_ctrl;

endpackage

// ===== rtl/pcma_lane.sv =====
// ----------------------------------------------------------------------------
// pcma_lane: one phase lane
// Registered absolute difference between a phase sample and the ADC bias.
// ----------------------------------------------------------------------------
module pcma_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pcma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [pcma_pkg::SAMPLE_W-1:0] i_bias,
    output logic [pcma_pkg::SAMPLE_W-1:0] o_diff
);
    import pcma_pkg::*;

    logic [SAMPLE_W-1:0] r_diff;
    logic [SAMPLE_W-1:0] n_diff;

    always_comb begin
        if (i_sample >= i_bias) begin
            n_diff = i_sample - i_bias;
        end else begin
            n_diff = i_bias - i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

// ===== rtl/pcma_ring.sv =====
// ----------------------------------------------------------------------------
// pcma_ring: lane merge, sample ring and running sum
// Merges the lane differences, updates the boxcar window and registers the
// averaged, clamped result in the output stage.
// ----------------------------------------------------------------------------
module pcma_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcma_pkg::t_ring_ctrl          i_ctrl,
    input  logic                          i_s1_valid,
    input  logic                          i_s1_running,
    input  logic [pcma_pkg::SAMPLE_W-1:0] i_diff_u,
    input  logic [pcma_pkg::SAMPLE_W-1:0] i_diff_v,
    input  logic [pcma_pkg::SAMPLE_W-1:0] i_diff_w,
    input  logic                          i_out_stall,
    output logic                          o_adv,
    output logic                          o_out_valid,
    output logic [pcma_pkg::SAMPLE_W-1:0] o_filtered
);
    import pcma_pkg::*;

    logic [SAMPLE_W-1:0] r_ring [MAX_WINDOW];
    logic [SUM_W-1:0]    r_sum;
    logic [RING_AW-1:0]  r_wr_pos;
    logic [FILL_W-1:0]   r_fill;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_result;

    logic [SUM_W-1:0]      n_sum;
    logic [RING_AW-1:0]    n_wr_pos;
    logic [FILL_W-1:0]     n_fill;
    logic [SAMPLE_W-1:0]   n_result;
    logic                  eff_wide;
    logic [RING_AW-1:0]    win_m1;
    logic [FILL_W-1:0]     win;
    logic [RING_AW-1:0]    pos;
    logic                  full;
    logic                  load;
    logic [DIFF_SUM_W-1:0] total;
    logic [DIFF_SUM_W-2:0] half;
    logic [SAMPLE_W-1:0]   v;
    logic [SAMPLE_W-1:0]   sub;
    logic [SUM_W-1:0]      shifted;

    assign eff_wide = i_ctrl.wide && (MAX_WINDOW >= 8);
    assign win_m1   = eff_wide ? RING_AW'(7) : RING_AW'(3);
    assign win      = FILL_W'(win_m1) + FILL_W'(1);
    assign pos      = r_wr_pos & win_m1;
    assign full     = (r_fill >= win);
    assign o_adv    = !r_out_valid || !i_out_stall;
    assign load     = o_adv && i_s1_valid;

    always_comb begin
        total = DIFF_SUM_W'(i_diff_u) + DIFF_SUM_W'(i_diff_v) + DIFF_SUM_W'(i_diff_w);
        half  = total[DIFF_SUM_W-1:1];
        if (half > (DIFF_SUM_W-1)'(SAMPLE_MAX)) begin
            v = SAMPLE_MAX;
        end else begin
            v = half[SAMPLE_W-1:0];
        end
        sub      = full ? r_ring[pos] : '0;
        n_sum    = r_sum - SUM_W'(sub) + SUM_W'(v);
        n_wr_pos = (pos + RING_AW'(1)) & win_m1;
        n_fill   = full ? r_fill : r_fill + FILL_W'(1);
        shifted  = eff_wide ? (n_sum >> 3) : (n_sum >> 2);
        if (shifted > SUM_W'(SAMPLE_MAX)) begin
            n_result = SAMPLE_MAX;
        end else begin
            n_result = shifted[SAMPLE_W-1:0];
        end
        if (i_s1_running && (n_result > i_ctrl.current_limit)) begin
            n_result = i_ctrl.current_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_sum    <= '0;
                r_wr_pos <= '0;
                r_fill   <= '0;
            end else if (load) begin
                r_sum    <= n_sum;
                r_wr_pos <= n_wr_pos;
                r_fill   <= n_fill;
            end
            if (o_adv) begin
                r_out_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_ctrl.clear) begin
            r_ring[pos] <= v;
        end
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_result;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= win)
        else $error("fill count beyond window");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos <= win_m1)
        else $error("write position outside window");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_fill == '0) && (r_sum == '0) && (r_wr_pos == '0))
        else $error("window clear did not empty the filter");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_s1_running) |=> (r_result <= $past(i_ctrl.current_limit)))
        else $error("running result above current limit");

endmodule

// ===== rtl/phase_current_moving_average.sv =====
// ----------------------------------------------------------------------------
// phase_current_moving_average: boxcar filter of phase current magnitude
// Each input transaction passes the lane register stage, then the output register, to o_valid.
// Throughput: one transaction per cycle unless i_stall holds the output; while a
// finished result waits in the output register, the lane register stage takes one more transaction.
// Reset (synchronous, active low) empties the window and loads register
// defaults; ring contents are not cleared, the fill count masks them.
// ----------------------------------------------------------------------------
module phase_current_moving_average (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pcma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pcma_pkg::SAMPLE_W-1:0]   i_phase_u_sample,
    input  logic [pcma_pkg::SAMPLE_W-1:0]   i_phase_v_sample,
    input  logic [pcma_pkg::SAMPLE_W-1:0]   i_phase_w_sample,
    input  logic                            i_motor_running,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pcma_pkg::SAMPLE_W-1:0]   o_filtered_current
);
    import pcma_pkg::*;

    logic [SAMPLE_W-1:0] r_adc_bias;
    logic [WLOG2_W-1:0]  r_window_log2;
    logic [SAMPLE_W-1:0] r_current_limit;
    logic                r_s1_valid;
    logic                r_s1_running;

    logic                s1_adv;
    logic                accept;
    logic                ring_adv;
    t_ring_ctrl          ring_ctrl;
    logic [SAMPLE_W-1:0] diff_u;
    logic [SAMPLE_W-1:0] diff_v;
    logic [SAMPLE_W-1:0] diff_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_bias      <= BIAS_RESET;
            r_window_log2   <= WLOG2_RESET;
            r_current_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_ADC_BIAS) begin
                r_adc_bias <= i_cfg_data[SAMPLE_W-1:0];
            end
            if (i_cfg_index == CFG_WINDOW_LOG2) begin
                r_window_log2 <= i_cfg_data[WLOG2_W-1:0];
            end
            if (i_cfg_index == CFG_CURRENT_LIMIT) begin
                r_current_limit <= i_cfg_data[SAMPLE_W-1:0];
            end
        end
    end

    assign ring_ctrl.clear         = i_cfg_wr_en && (i_cfg_index == CFG_WINDOW_LOG2);
    assign ring_ctrl.wide          = (r_window_log2 == WLOG2_WIDE);
    assign ring_ctrl.current_limit = r_current_limit;

    assign s1_adv  = !r_s1_valid || ring_adv;
    assign accept  = i_valid && s1_adv;
    assign o_stall = !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_running <= i_motor_running;
        end
    end

    pcma_lane u_lane_u (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_sample (i_phase_u_sample),
        .i_bias   (r_adc_bias),
        .o_diff   (diff_u)
    );

    pcma_lane u_lane_v (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_sample (i_phase_v_sample),
        .i_bias   (r_adc_bias),
        .o_diff   (diff_v)
    );

    pcma_lane u_lane_w (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_sample (i_phase_w_sample),
        .i_bias   (r_adc_bias),
        .o_diff   (diff_w)
    );

    pcma_ring u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ring_ctrl),
        .i_s1_valid   (r_s1_valid),
        .i_s1_running (r_s1_running),
        .i_diff_u     (diff_u),
        .i_diff_v     (diff_v),
        .i_diff_w     (diff_w),
        .i_out_stall  (i_stall),
        .o_adv        (ring_adv),
        .o_out_valid  (o_valid),
        .o_filtered   (o_filtered_current)
    );

endmodule

// ===== tb/phase_current_moving_average_tb.sv =====
// ----------------------------------------------------------------------------
// phase_current_moving_average_tb: self-checking bench for the boxcar filter
// Drives ADC triples with random gaps and output stalls. A scoreboard class
// keeps its own copy of the window state and the register settings and
// predicts every filtered current. Results are compared in order. The run
// covers directed extremes and then random phases under varied settings.
// ----------------------------------------------------------------------------
module phase_current_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcma_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 85;

    class filter_scoreboard;
        logic [SAMPLE_W-1:0] adc_bias;
        logic [WLOG2_W-1:0]  window_sel;
        logic [SAMPLE_W-1:0] current_limit;
        logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
        logic [SUM_W-1:0]    ring_sum;
        int                  write_slot;
        int                  fill_level;
        logic [SAMPLE_W-1:0] expected_current [$];
        int                  error_count;

        function new();
            adc_bias      = BIAS_RESET;
            window_sel    = WLOG2_RESET;
            current_limit = LIMIT_RESET;
            ring_sum      = '0;
            write_slot    = 0;
            fill_level    = 0;
            error_count   = 0;
        endfunction

        function void apply_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ADC_BIAS: begin
                    adc_bias = data;
                end
                CFG_WINDOW_LOG2: begin
                    window_sel = data[WLOG2_W-1:0];
                    ring_sum   = '0;
                    write_slot = 0;
                    fill_level = 0;
                end
                CFG_CURRENT_LIMIT: begin
                    current_limit = data;
                end
                default: begin
                end
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] abs_offset(logic [SAMPLE_W-1:0] s);
            return (s >= adc_bias) ? s - adc_bias : adc_bias - s;
        endfunction

        function void accept_sample_set(logic [SAMPLE_W-1:0] u, logic [SAMPLE_W-1:0] v,
                                        logic [SAMPLE_W-1:0] w, logic run);
            logic [DIFF_SUM_W-1:0] total;
            logic [SAMPLE_W-1:0]   entry;
            logic [SUM_W-1:0]      avg;
            logic [SAMPLE_W-1:0]   result;
            int                    lg;
            int                    span;
            int                    slot;
            lg = (window_sel >= WLOG2_WIDE) ? 3 : 2;
            while (lg > 0 && (1 << lg) > MAX_WINDOW) lg--;
            span  = 1 << lg;
            total = DIFF_SUM_W'(abs_offset(u)) + DIFF_SUM_W'(abs_offset(v))
                  + DIFF_SUM_W'(abs_offset(w));
            entry = ((total >> 1) > SAMPLE_MAX) ? SAMPLE_MAX : total[SAMPLE_W:1];
            slot  = write_slot % span;
            if (fill_level < span) begin
                fill_level++;
            end else begin
                ring_sum -= SUM_W'(ring[slot]);
            end
            ring[slot] = entry;
            ring_sum  += SUM_W'(entry);
            write_slot = (slot + 1) % span;
            avg    = ring_sum >> lg;
            result = (avg > SAMPLE_MAX) ? SAMPLE_MAX : avg[SAMPLE_W-1:0];
            if (run && result > current_limit) begin
                result = current_limit;
            end
            expected_current.push_back(result);
        endfunction

        function void check_filtered(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] want;
            if (expected_current.size() == 0) begin
                error_count++;
                $error("filtered_current: expected none, actual %0d", actual);
            end else begin
                want = expected_current.pop_front();
                if (actual !== want) begin
                    error_count++;
                    $error("filtered_current: expected %0d, actual %0d", want, actual);
                end
            end
        endfunction
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = CFG_ADC_BIAS;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_phase_u_sample = '0;
    logic [SAMPLE_W-1:0]   i_phase_v_sample = '0;
    logic [SAMPLE_W-1:0]   i_phase_w_sample = '0;
    logic                  i_motor_running  = 1'b0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [SAMPLE_W-1:0]   o_filtered_current;

    logic                  no_idle          = 1'b0;
    int                    cycle_count      = 0;
    filter_scoreboard      sb;

    phase_current_moving_average dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_phase_u_sample   (i_phase_u_sample),
        .i_phase_v_sample   (i_phase_v_sample),
        .i_phase_w_sample   (i_phase_w_sample),
        .i_motor_running    (i_motor_running),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_filtered_current (o_filtered_current)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL phase_current_moving_average");
            $finish;
        end
    end

    // result side: check before the stall for the next cycle is drawn
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_filtered(o_filtered_current);
        end
        i_stall <= !no_idle && ($urandom_range(99) < 20);
    end

    task automatic send_item(input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v,
                             input logic [SAMPLE_W-1:0] w, input logic run);
        while (!no_idle && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_phase_u_sample <= u;
        i_phase_v_sample <= v;
        i_phase_w_sample <= w;
        i_motor_running  <= run;
        do @(posedge i_clk); while (o_stall);
        sb.accept_sample_set(u, v, w, run);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_current.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
        int s;
        case (mode)
            0: s = $urandom_range(4095);
            1: begin
                s = $urandom_range(64);
                s = s - 32 + int'(sb.adc_bias);
            end
            default: begin
                if ($urandom_range(2) == 0) s = 0;
                else if ($urandom_range(1) == 1) s = 4095;
                else s = int'(sb.adc_bias);
            end
        endcase
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(3))
            0: return '0;
            1: return SAMPLE_MAX;
            default: return CFG_DATA_W'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        int mode;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero bias, four-entry window, limit 2000
        send_item(12'd0, 12'd0, 12'd0, 1'b0);
        send_item(12'd4095, 12'd4095, 12'd4095, 1'b0);
        send_item(12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_item(12'd4095, 12'd0, 12'd4095, 1'b0);
        send_item(12'd1, 12'd2, 12'd4, 1'b1);
        send_item(12'd4095, 12'd4095, 12'd4095, 1'b1);
        drain();

        write_reg(CFG_ADC_BIAS, 12'd4095);
        write_reg(CFG_CURRENT_LIMIT, 12'd0);
        send_item(12'd0, 12'd0, 12'd0, 1'b1);
        send_item(12'd4095, 12'd4095, 12'd4095, 1'b0);
        send_item(12'd0, 12'd4095, 12'd0, 1'b0);
        drain();

        write_reg(CFG_ADC_BIAS, 12'd2048);
        write_reg(CFG_CURRENT_LIMIT, 12'd4095);
        write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'(WLOG2_WIDE));
        for (int i = 0; i < 9; i++) begin
            send_item(i[0] ? 12'd4095 : 12'd0, (i < 5) ? 12'd0 : 12'd2048,
                      12'(i * 455), i[0]);
        end
        drain();

        // selector values below two fall back to four entries
        write_reg(CFG_WINDOW_LOG2, 12'd0);
        for (int i = 0; i < 4; i++) begin
            send_item(12'd0, 12'd4095, 12'(i * 1000), 1'b1);
        end
        drain();
        write_reg(CFG_WINDOW_LOG2, 12'd1);
        for (int i = 0; i < 3; i++) begin
            send_item(12'd4095, 12'd0, 12'(4095 - i * 1000), 1'b0);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(CFG_ADC_BIAS, pick_level());
            write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'($urandom_range(3)));
            write_reg(CFG_CURRENT_LIMIT, pick_level());
            no_idle <= (p == PHASES / 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                mode = $urandom_range(2);
                send_item(pick_sample(mode), pick_sample(mode), pick_sample(mode),
                          1'($urandom_range(1)));
            end
        end
        no_idle <= 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        if (sb.error_count == 0 && sb.expected_current.size() == 0) begin
            $display("PASS phase_current_moving_average");
        end else begin
            $display("FAIL phase_current_moving_average");
        end
        $finish;
    end
endmodule
